@@ hw/rtl/alignment_read_gate_filter_core_defines.svh @@
// Assertion macros for the alignment read gate filter RTL.
`ifndef ALIGNMENT_READ_GATE_FILTER_CORE_DEFINES_SVH
`define ALIGNMENT_READ_GATE_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define ARGF_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("alignment read gate filter: implication failed");

// Next-cycle implication that also holds across reset.
`define ARGF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("alignment read gate filter: next-cycle check failed");

`endif

@@ hw/rtl/argf_pkg.sv @@
// Types, constants and helpers shared by the alignment read gate filter modules.
`timescale 1ns / 1ps

package argf_pkg;

   localparam int LEN_WIDTH   = 28;
   localparam int ACC_WIDTH   = 32;
   localparam int FLAG_WIDTH  = 16;
   localparam int MAPQ_WIDTH  = 8;
   localparam int EDIT_WIDTH  = 24;
   localparam int RATE_WIDTH  = 20;
   localparam int RATE_SHIFT  = 16;
   localparam int REASON_WIDTH = 3;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int PROD_WIDTH  = ACC_WIDTH + RATE_WIDTH;

   // Alignment flag bit positions.
   localparam int FLAG_UNMAPPED_BIT      = 2;
   localparam int FLAG_SECONDARY_BIT     = 8;
   localparam int FLAG_SUPPLEMENTARY_BIT = 11;

   // CIGAR operation codes.
   typedef enum logic [3:0] {
      OP_MATCH     = 4'd0,
      OP_INSERT    = 4'd1,
      OP_DELETE    = 4'd2,
      OP_SKIP      = 4'd3,
      OP_SOFT_CLIP = 4'd4,
      OP_HARD_CLIP = 4'd5,
      OP_PAD       = 4'd6,
      OP_SEQ_MATCH = 4'd7,
      OP_MISMATCH  = 4'd8
   } cigar_op_type;

   // Gate reason codes.
   localparam logic [REASON_WIDTH-1:0] REASON_PASS        = 3'd0;
   localparam logic [REASON_WIDTH-1:0] REASON_UNMAPPED    = 3'd1;
   localparam logic [REASON_WIDTH-1:0] REASON_SHORT       = 3'd2;
   localparam logic [REASON_WIDTH-1:0] REASON_LOW_MAPQ    = 3'd3;
   localparam logic [REASON_WIDTH-1:0] REASON_ANCHOR      = 3'd4;
   localparam logic [REASON_WIDTH-1:0] REASON_LEAD_FLANK  = 3'd5;
   localparam logic [REASON_WIDTH-1:0] REASON_TRAIL_FLANK = 3'd6;
   localparam logic [REASON_WIDTH-1:0] REASON_EDIT_RATE   = 3'd7;

   // Configuration register indices.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_READ_LENGTH     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_CLIP_MIN       = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAPQ_FLOOR          = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_ANCHOR_BASES    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_FLANK_BASES     = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_EDIT_RATE       = 3'd5;

   // Configuration reset values.
   localparam logic [LEN_WIDTH-1:0]  RST_MIN_READ_LENGTH     = 28'd0;
   localparam logic [LEN_WIDTH-1:0]  RST_LONG_CLIP_MIN       = 28'd20;
   localparam logic [MAPQ_WIDTH-1:0] RST_MAPQ_FLOOR          = 8'd20;
   localparam logic [LEN_WIDTH-1:0]  RST_MIN_ANCHOR_BASES    = 28'd30;
   localparam logic [LEN_WIDTH-1:0]  RST_MIN_FLANK_BASES     = 28'd20;
   localparam logic [RATE_WIDTH-1:0] RST_MAX_EDIT_RATE       = 20'd65536;

   typedef struct packed {
      logic [LEN_WIDTH-1:0]  min_read_length;
      logic [LEN_WIDTH-1:0]  long_clip_min;
      logic [MAPQ_WIDTH-1:0] mapq_floor;
      logic [LEN_WIDTH-1:0]  min_anchor_bases;
      logic [LEN_WIDTH-1:0]  min_flank_bases;
      logic [RATE_WIDTH-1:0] max_edit_rate;
   } cfg_type;

   // One CIGAR operation as it enters the tracker.
   typedef struct packed {
      logic                 has_op;
      logic [3:0]           op_code;
      logic [LEN_WIDTH-1:0] op_length;
      logic                 is_last;
   } op_item_type;

   // Read-level fields, meaningful on the last operation only.
   typedef struct packed {
      logic [FLAG_WIDTH-1:0] flag_bits;
      logic [LEN_WIDTH-1:0]  read_length;
      logic [MAPQ_WIDTH-1:0] mapping_quality;
      logic                  has_split_tag;
      logic                  edit_present;
      logic [EDIT_WIDTH-1:0] edit_distance;
   } read_type;

   // Per-read CIGAR summary handed to the gate.
   typedef struct packed {
      logic [ACC_WIDTH-1:0] total_match;
      logic [ACC_WIDTH-1:0] longest_block;
      logic [LEN_WIDTH-1:0] longest_soft_clip;
      logic [LEN_WIDTH-1:0] leading_clip_len;
      logic [ACC_WIDTH-1:0] lead_flank;
      logic [LEN_WIDTH-1:0] trailing_clip_len;
      logic [ACC_WIDTH-1:0] trail_flank;
   } summary_type;

   // Saturating add of an operation length onto a 32-bit accumulator.
   function automatic logic [ACC_WIDTH-1:0] sat_add(input logic [ACC_WIDTH-1:0] acc,
                                                     input logic [LEN_WIDTH-1:0] len);
      logic [ACC_WIDTH:0] sum;
      sum = {1'b0, acc} + {{(ACC_WIDTH - LEN_WIDTH + 1){1'b0}}, len};
      return sum[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : sum[ACC_WIDTH-1:0];
   endfunction

endpackage

@@ hw/rtl/argf_track.sv @@
// CIGAR operation tracker: running per-read summaries, cleared after each read.
`timescale 1ns / 1ps

module argf_track
   import argf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   input  op_item_type item,
   input  logic        gate_ready,
   output logic        item_take,
   output logic        summary_valid,
   output summary_type summary
);

   logic [ACC_WIDTH-1:0] total_match_ff, total_match_in;
   logic [ACC_WIDTH-1:0] longest_block_ff, longest_block_in;
   logic [ACC_WIDTH-1:0] current_block_ff, current_block_in;
   logic [LEN_WIDTH-1:0] longest_soft_clip_ff, longest_soft_clip_in;
   logic                 seen_non_hard_ff, seen_non_hard_in;
   logic [LEN_WIDTH-1:0] leading_clip_len_ff, leading_clip_len_in;
   logic                 scanning_lead_flank_ff, scanning_lead_flank_in;
   logic [ACC_WIDTH-1:0] lead_flank_ff, lead_flank_in;
   logic [LEN_WIDTH-1:0] trailing_clip_len_ff, trailing_clip_len_in;
   logic [ACC_WIDTH-1:0] trail_flank_ff, trail_flank_in;

   // Values after the current operation, before any end-of-read clear.
   logic [ACC_WIDTH-1:0] upd_total_match;
   logic [ACC_WIDTH-1:0] upd_longest_block;
   logic [ACC_WIDTH-1:0] upd_current_block;
   logic [LEN_WIDTH-1:0] upd_longest_soft_clip;
   logic                 upd_seen_non_hard;
   logic [LEN_WIDTH-1:0] upd_leading_clip_len;
   logic                 upd_scanning_lead_flank;
   logic [ACC_WIDTH-1:0] upd_lead_flank;
   logic [LEN_WIDTH-1:0] upd_trailing_clip_len;
   logic [ACC_WIDTH-1:0] upd_trail_flank;

   logic is_match;
   logic is_soft;
   logic is_hard;

   // Operation class decode.
   always_comb begin
      is_match = 1'b0;
      case (item.op_code) inside
         OP_MATCH, OP_SEQ_MATCH, OP_MISMATCH: is_match = 1'b1;
         default:                             is_match = 1'b0;
      endcase
      is_soft = (item.op_code == OP_SOFT_CLIP);
      is_hard = (item.op_code == OP_HARD_CLIP);
   end

   // Apply one operation to the running summaries.
   always_comb begin
      upd_total_match         = total_match_ff;
      upd_longest_block       = longest_block_ff;
      upd_current_block       = current_block_ff;
      upd_longest_soft_clip   = longest_soft_clip_ff;
      upd_seen_non_hard       = seen_non_hard_ff;
      upd_leading_clip_len    = leading_clip_len_ff;
      upd_scanning_lead_flank = scanning_lead_flank_ff;
      upd_lead_flank          = lead_flank_ff;
      upd_trailing_clip_len   = trailing_clip_len_ff;
      upd_trail_flank         = trail_flank_ff;

      if (item.has_op) begin
         // The leading flank grows only through match-like operations.
         if (scanning_lead_flank_ff) begin
            if (is_match) begin
               upd_lead_flank = sat_add(lead_flank_ff, item.op_length);
            end else begin
               upd_scanning_lead_flank = 1'b0;
            end
         end

         // End analysis ignores hard clips.
         if (!is_hard) begin
            if (!seen_non_hard_ff) begin
               upd_seen_non_hard = 1'b1;
               if (is_soft) begin
                  upd_leading_clip_len    = item.op_length;
                  upd_scanning_lead_flank = 1'b1;
               end
            end
            if (is_soft) begin
               upd_trailing_clip_len = item.op_length;
               upd_trail_flank       = current_block_ff;
            end else begin
               upd_trailing_clip_len = '0;
               upd_trail_flank       = '0;
            end
         end

         // Match totals and the running block.
         if (is_match) begin
            upd_total_match   = sat_add(total_match_ff, item.op_length);
            upd_current_block = sat_add(current_block_ff, item.op_length);
            if (upd_current_block > longest_block_ff) begin
               upd_longest_block = upd_current_block;
            end
         end else begin
            upd_current_block = '0;
         end

         if (is_soft && (item.op_length > longest_soft_clip_ff)) begin
            upd_longest_soft_clip = item.op_length;
         end
      end
   end

   // Handshake towards the input register and the gate.
   assign item_take     = item_valid && (!item.is_last || gate_ready);
   assign summary_valid = item_valid && item.is_last && gate_ready;

   always_comb begin
      summary.total_match       = upd_total_match;
      summary.longest_block     = upd_longest_block;
      summary.longest_soft_clip = upd_longest_soft_clip;
      summary.leading_clip_len  = upd_leading_clip_len;
      summary.lead_flank        = upd_lead_flank;
      summary.trailing_clip_len = upd_trailing_clip_len;
      summary.trail_flank       = upd_trail_flank;
   end

   // The state returns to zero once the last operation of a read is taken.
   always_comb begin
      if (item.is_last) begin
         total_match_in         = '0;
         longest_block_in       = '0;
         current_block_in       = '0;
         longest_soft_clip_in   = '0;
         seen_non_hard_in       = 1'b0;
         leading_clip_len_in    = '0;
         scanning_lead_flank_in = 1'b0;
         lead_flank_in          = '0;
         trailing_clip_len_in   = '0;
         trail_flank_in         = '0;
      end else begin
         total_match_in         = upd_total_match;
         longest_block_in       = upd_longest_block;
         current_block_in       = upd_current_block;
         longest_soft_clip_in   = upd_longest_soft_clip;
         seen_non_hard_in       = upd_seen_non_hard;
         leading_clip_len_in    = upd_leading_clip_len;
         scanning_lead_flank_in = upd_scanning_lead_flank;
         lead_flank_in          = upd_lead_flank;
         trailing_clip_len_in   = upd_trailing_clip_len;
         trail_flank_in         = upd_trail_flank;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_match_ff         <= '0;
         longest_block_ff       <= '0;
         current_block_ff       <= '0;
         longest_soft_clip_ff   <= '0;
         seen_non_hard_ff       <= 1'b0;
         leading_clip_len_ff    <= '0;
         scanning_lead_flank_ff <= 1'b0;
         lead_flank_ff          <= '0;
         trailing_clip_len_ff   <= '0;
         trail_flank_ff         <= '0;
      end else if (item_take) begin
         total_match_ff         <= total_match_in;
         longest_block_ff       <= longest_block_in;
         current_block_ff       <= current_block_in;
         longest_soft_clip_ff   <= longest_soft_clip_in;
         seen_non_hard_ff       <= seen_non_hard_in;
         leading_clip_len_ff    <= leading_clip_len_in;
         scanning_lead_flank_ff <= scanning_lead_flank_in;
         lead_flank_ff          <= lead_flank_in;
         trailing_clip_len_ff   <= trailing_clip_len_in;
         trail_flank_ff         <= trail_flank_in;
      end
   end

endmodule

@@ hw/rtl/argf_gate.sv @@
// Read gate: threshold checks, edit-rate product and the result register.
`timescale 1ns / 1ps

module argf_gate
   import argf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    in_valid,
   input  summary_type             in_summary,
   input  read_type                in_read,
   output logic                    in_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_pass,
   output logic [REASON_WIDTH-1:0] rsp_reason
);

   // Stage one: captured summary and read fields.
   logic        s1_valid_ff, s1_valid_in;
   summary_type s1_sum_ff;
   read_type    s1_read_ff;

   // Stage two: early reason, edit-rate product and operands.
   logic                    s2_valid_ff, s2_valid_in;
   logic [REASON_WIDTH-1:0] s2_reason_ff, s2_reason_in;
   logic                    s2_check_ff, s2_check_in;
   logic [PROD_WIDTH-1:0]   s2_product_ff, s2_product_in;
   logic [EDIT_WIDTH-1:0]   s2_edit_ff;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [REASON_WIDTH-1:0] rsp_reason_ff, rsp_reason_in;

   logic out_free;
   logic s2_free;
   logic s1_free;
   logic s1_load;
   logic s2_load;
   logic rsp_load;

   logic unmapped;
   logic short_read;
   logic long_clip;
   logic signal_read;
   logic [PROD_WIDTH-1:0] edit_scaled;
   logic edit_fail;

   // Each stage moves when the one after it is empty or moving.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s2_free  = !s2_valid_ff || out_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign in_ready = s1_free;

   assign s1_load  = in_valid && s1_free;
   assign s2_load  = s1_valid_ff && s2_free;
   assign rsp_load = s2_valid_ff && out_free;

   assign s1_valid_in  = s1_free ? in_valid : s1_valid_ff;
   assign s2_valid_in  = s2_free ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = out_free ? s2_valid_ff : rsp_valid_ff;

   // Threshold checks in priority order.
   always_comb begin
      unmapped    = s1_read_ff.flag_bits[FLAG_UNMAPPED_BIT] ||
                    s1_read_ff.flag_bits[FLAG_SECONDARY_BIT];
      short_read  = s1_read_ff.read_length < cfg.min_read_length;
      long_clip   = s1_sum_ff.longest_soft_clip >= cfg.long_clip_min;
      signal_read = s1_read_ff.flag_bits[FLAG_SUPPLEMENTARY_BIT] ||
                    s1_read_ff.has_split_tag || long_clip;

      s2_check_in  = 1'b0;
      s2_reason_in = REASON_PASS;
      if (unmapped) begin
         s2_reason_in = REASON_UNMAPPED;
      end else if (short_read) begin
         s2_reason_in = REASON_SHORT;
      end else if (!signal_read) begin
         if (s1_read_ff.mapping_quality <= cfg.mapq_floor) begin
            s2_reason_in = REASON_LOW_MAPQ;
         end
      end else if (s1_sum_ff.longest_block <
                   {{(ACC_WIDTH - LEN_WIDTH){1'b0}}, cfg.min_anchor_bases}) begin
         s2_reason_in = REASON_ANCHOR;
      end else if (long_clip &&
                   (s1_sum_ff.leading_clip_len >= cfg.long_clip_min) &&
                   (s1_sum_ff.lead_flank <
                    {{(ACC_WIDTH - LEN_WIDTH){1'b0}}, cfg.min_flank_bases})) begin
         s2_reason_in = REASON_LEAD_FLANK;
      end else if (long_clip &&
                   (s1_sum_ff.trailing_clip_len >= cfg.long_clip_min) &&
                   (s1_sum_ff.trail_flank <
                    {{(ACC_WIDTH - LEN_WIDTH){1'b0}}, cfg.min_flank_bases})) begin
         s2_reason_in = REASON_TRAIL_FLANK;
      end else begin
         s2_check_in = s1_read_ff.edit_present && (s1_sum_ff.total_match != '0);
      end
   end

   // Allowed edits scaled by the aligned bases: rate * total, 20 x 32 bits.
   assign s2_product_in = {{RATE_WIDTH{1'b0}}, s1_sum_ff.total_match} *
                          {{ACC_WIDTH{1'b0}}, cfg.max_edit_rate};

   // Edit distance in units of 1/65536 against the allowance.
   assign edit_scaled = {{(PROD_WIDTH - EDIT_WIDTH - RATE_SHIFT){1'b0}},
                         s2_edit_ff, {RATE_SHIFT{1'b0}}};
   assign edit_fail   = s2_check_ff && (edit_scaled > s2_product_ff);

   assign rsp_reason_in = edit_fail ? REASON_EDIT_RATE : s2_reason_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_sum_ff  <= in_summary;
         s1_read_ff <= in_read;
      end
      if (s2_load) begin
         s2_reason_ff  <= s2_reason_in;
         s2_check_ff   <= s2_check_in;
         s2_product_ff <= s2_product_in;
         s2_edit_ff    <= s1_read_ff.edit_distance;
      end
      if (rsp_load) begin
         rsp_reason_ff <= rsp_reason_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_reason = rsp_reason_ff;
   assign rsp_pass   = (rsp_reason_ff == REASON_PASS);

endmodule

@@ hw/rtl/alignment_read_gate_filter_core.sv @@
// Top level of the alignment read gate filter: ports, configuration and request register.
`timescale 1ns / 1ps
`include "alignment_read_gate_filter_core_defines.svh"

// The block takes one CIGAR operation per request and can accept a request in
// every clock cycle while req_stall is low. The request marked last closes the
// read and produces one result (pass and a reason code); other requests produce
// none. A result appears on rsp_valid after its last request has passed through
// the request register, during which the operation tracker works on it and
// updates its running registers, clearing them for the next read, and through
// the gate's stage one, stage two and result registers; stage two registers the
// 20 x 32 bit edit-rate product before the final compare. Stalls on the result
// side back up through the pipeline to req_stall; requests that are not last
// keep flowing while only the result side is stalled, until a last request finds
// the gate full. Configuration is written through csr_write_enable, csr_index
// and csr_write_data; the user must write it only while the block is idle, which
// the block itself does not enforce; writes to indices above five are ignored.

module alignment_read_gate_filter_core
   import argf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_has_op,
   input  logic [3:0]                 req_op_code,
   input  logic [LEN_WIDTH-1:0]       req_op_length,
   input  logic                       req_is_last,
   input  logic [FLAG_WIDTH-1:0]      req_flag_bits,
   input  logic [LEN_WIDTH-1:0]       req_read_length,
   input  logic [MAPQ_WIDTH-1:0]      req_mapping_quality,
   input  logic                       req_has_split_tag,
   input  logic                       req_edit_present,
   input  logic [EDIT_WIDTH-1:0]      req_edit_distance,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_pass,
   output logic [REASON_WIDTH-1:0]    rsp_reason,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [LEN_WIDTH-1:0]       csr_write_data
);

   cfg_type     cfg_ff, cfg_in;
   logic        in_valid_ff, in_valid_in;
   op_item_type in_op_ff;
   read_type    in_read_ff;

   logic        req_take;
   logic        item_take;
   logic        gate_ready;
   logic        summary_valid;
   summary_type summary;

   // Configuration register decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MIN_READ_LENGTH:     cfg_in.min_read_length     = csr_write_data;
            CSR_LONG_CLIP_MIN:       cfg_in.long_clip_min       = csr_write_data;
            CSR_MAPQ_FLOOR:          cfg_in.mapq_floor          = csr_write_data[MAPQ_WIDTH-1:0];
            CSR_MIN_ANCHOR_BASES:    cfg_in.min_anchor_bases    = csr_write_data;
            CSR_MIN_FLANK_BASES:     cfg_in.min_flank_bases     = csr_write_data;
            CSR_MAX_EDIT_RATE:       cfg_in.max_edit_rate       = csr_write_data[RATE_WIDTH-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_read_length     <= RST_MIN_READ_LENGTH;
         cfg_ff.long_clip_min       <= RST_LONG_CLIP_MIN;
         cfg_ff.mapq_floor          <= RST_MAPQ_FLOOR;
         cfg_ff.min_anchor_bases    <= RST_MIN_ANCHOR_BASES;
         cfg_ff.min_flank_bases     <= RST_MIN_FLANK_BASES;
         cfg_ff.max_edit_rate       <= RST_MAX_EDIT_RATE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request register: refilled whenever its request moves on.
   assign req_stall   = in_valid_ff && !item_take;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !item_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff.has_op             <= req_has_op;
         in_op_ff.op_code            <= req_op_code;
         in_op_ff.op_length          <= req_op_length;
         in_op_ff.is_last            <= req_is_last;
         in_read_ff.flag_bits        <= req_flag_bits;
         in_read_ff.read_length      <= req_read_length;
         in_read_ff.mapping_quality  <= req_mapping_quality;
         in_read_ff.has_split_tag    <= req_has_split_tag;
         in_read_ff.edit_present     <= req_edit_present;
         in_read_ff.edit_distance    <= req_edit_distance;
      end
   end

   // Running CIGAR summaries.
   argf_track u_track (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (in_valid_ff),
      .item          (in_op_ff),
      .gate_ready    (gate_ready),
      .item_take     (item_take),
      .summary_valid (summary_valid),
      .summary       (summary)
   );

   // Read-level gate and result register.
   argf_gate u_gate (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (summary_valid),
      .in_summary (summary),
      .in_read    (in_read_ff),
      .in_ready   (gate_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_pass   (rsp_pass),
      .rsp_reason (rsp_reason)
   );

   // A stall is only raised while the request register holds a request.
   `ARGF_ASSERT_IMPLY(a_stall_needs_item, req_stall, in_valid_ff)
   // A request that does not close a read never waits on the gate.
   `ARGF_ASSERT_IMPLY(a_mid_read_flows, in_valid_ff && !in_op_ff.is_last, !req_stall)
   // The gate only takes a summary when a last request leaves the request register.
   `ARGF_ASSERT_IMPLY(a_summary_on_last, summary_valid, item_take && in_op_ff.is_last)
   // No result is offered in the cycle after reset.
   `ARGF_ASSERT_NEXT(a_reset_empty, reset, !rsp_valid)

endmodule
